[rtl/vrp_pkg.sv]
// Shared types and constants for the vector rotate and polar unit.
// Used by every module in rtl; depends on nothing else.
package vrp_pkg;

   typedef enum logic [1:0] {
      OP_ROTATE = 2'd0,
      OP_VECTOR = 2'd1,
      OP_POLAR  = 2'd2
   } op_type;

   typedef struct packed {
      op_type op;
      logic   zero_vec;
   } ctl_type;

   // guard bits above the input scale: range, CORDIC growth and sign
   localparam int GUARD_BITS   = 7;
   // angle path: 2^32 units per turn plus one bit of headroom
   localparam int ZW           = 33;
   localparam int ATAN_ENTRIES = 24;
   localparam int KGAIN_W      = 25;
   localparam logic signed [KGAIN_W-1:0] KGAIN = 25'sd10187702;
   localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sd1073741824;
   localparam logic signed [ZW-1:0] HEADING_RND  = 33'sd32768;

   localparam int COORD_OUT_W = 17;
   localparam int MAG_OUT_W   = 16;
   localparam int HEAD_OUT_W  = 16;
   localparam int COORD_MIN   = -65536;
   localparam int COORD_MAX   = 65535;
   localparam int MAG_MAX     = 65535;

   // atan(2^-i), 2^32 units per turn
   localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

endpackage

[rtl/vrp_prerot.sv]
// Entry stage: scales the request to the internal format and applies the
// quarter-turn pre-rotation. Depends on vrp_pkg.
module vrp_prerot #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [1:0]                              in_op,
   input  logic signed [15:0]                      in_x,
   input  logic signed [15:0]                      in_y,
   input  logic signed [15:0]                      in_angle,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output vrp_pkg::ctl_type                        out_ctl,
   output logic signed [DATA_WIDTH+vrp_pkg::GUARD_BITS-1:0] out_x,
   output logic signed [DATA_WIDTH+vrp_pkg::GUARD_BITS-1:0] out_y,
   output logic signed [vrp_pkg::ZW-1:0]           out_z
);
   import vrp_pkg::*;

   localparam int W  = DATA_WIDTH + GUARD_BITS;
   localparam int UP = (DATA_WIDTH >= 12) ? DATA_WIDTH - 12 : 0;
   localparam int DN = (DATA_WIDTH >= 12) ? 0 : 12 - DATA_WIDTH;

   logic                 valid_ff;
   ctl_type              ctl_ff, ctl_in;
   logic signed [W-1:0]  x_ff, y_ff, x_in, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   logic signed [W+15:0] xe, ye;
   logic signed [W-1:0]  xi, yi;
   logic signed [ZW-1:0] za;

   assign in_ready = !valid_ff || out_ready;

   assign xe = (W+16)'(in_x);
   assign ye = (W+16)'(in_y);
   assign xi = W'((xe <<< UP) >>> DN);
   assign yi = W'((ye <<< UP) >>> DN);
   assign za = ZW'(in_angle) <<< 16;

   always_comb begin
      ctl_in.op       = op_type'(in_op);
      ctl_in.zero_vec = (in_x == 16'sd0) && (in_y == 16'sd0);
      x_in = xi;
      y_in = yi;
      z_in = za;
      if (ctl_in.op == OP_VECTOR) begin
         priority if (xi < 0 && yi >= 0) begin
            x_in = yi;
            y_in = -xi;
            z_in = QUARTER_TURN;
         end else if (xi < 0) begin
            x_in = -yi;
            y_in = xi;
            z_in = -QUARTER_TURN;
         end else begin
            z_in = '0;
         end
      end else begin
         if (ctl_in.op == OP_POLAR) begin
            y_in = '0;
         end
         priority if (za > QUARTER_TURN) begin
            x_in = (ctl_in.op == OP_POLAR) ? W'(0) : -yi;
            y_in = xi;
            z_in = za - QUARTER_TURN;
         end else if (za < -QUARTER_TURN) begin
            x_in = (ctl_in.op == OP_POLAR) ? W'(0) : yi;
            y_in = -xi;
            z_in = za + QUARTER_TURN;
         end else begin
            z_in = za;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ctl_ff <= ctl_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

[rtl/vrp_cell.sv]
// One CORDIC micro-rotation stage with its own handshake register.
// Depends on vrp_pkg; chained by the top level.
module vrp_cell #(
   parameter int W     = 23,
   parameter int INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  vrp_pkg::ctl_type               in_ctl,
   input  logic signed [W-1:0]            in_x,
   input  logic signed [W-1:0]            in_y,
   input  logic signed [vrp_pkg::ZW-1:0]  in_z,
   output logic                           out_valid,
   input  logic                           out_ready,
   output vrp_pkg::ctl_type               out_ctl,
   output logic signed [W-1:0]            out_x,
   output logic signed [W-1:0]            out_y,
   output logic signed [vrp_pkg::ZW-1:0]  out_z
);
   import vrp_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TAB[INDEX]);

   logic                 valid_ff;
   ctl_type              ctl_ff;
   logic signed [W-1:0]  x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [ZW-1:0] z_ff, z_in;
   logic                 pos;

   assign in_ready = !valid_ff || out_ready;

   // rotate towards z = 0, or towards y = 0 when vectoring
   assign pos = (in_ctl.op == OP_VECTOR) ? in_y[W-1] : !in_z[ZW-1];
   assign dx  = in_y >>> INDEX;
   assign dy  = in_x >>> INDEX;

   always_comb begin
      if (pos) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ctl_ff <= in_ctl;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl   = ctl_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

[rtl/vrp_gain.sv]
// Gain compensation, rounding, saturation and the response register.
// Three stages: split multiply, round to Q12, clamp and select. Depends on vrp_pkg.
module vrp_gain #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  vrp_pkg::ctl_type                        in_ctl,
   input  logic signed [DATA_WIDTH+vrp_pkg::GUARD_BITS-1:0] in_x,
   input  logic signed [DATA_WIDTH+vrp_pkg::GUARD_BITS-1:0] in_y,
   input  logic signed [vrp_pkg::ZW-1:0]           in_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [vrp_pkg::COORD_OUT_W-1:0]  rsp_out_x,
   output logic signed [vrp_pkg::COORD_OUT_W-1:0]  rsp_out_y,
   output logic [vrp_pkg::MAG_OUT_W-1:0]           rsp_magnitude,
   output logic signed [vrp_pkg::HEAD_OUT_W-1:0]   rsp_heading
);
   import vrp_pkg::*;

   localparam int W   = DATA_WIDTH + GUARD_BITS;
   localparam int L   = W / 2;
   localparam int HW  = W - L;
   localparam int PHW = HW + KGAIN_W;
   localparam int PLW = L + 1 + KGAIN_W;
   localparam int P   = W + KGAIN_W + 1;
   localparam int S   = DATA_WIDTH + 12;
   localparam int QW  = P - S;
   localparam logic signed [P-1:0] RND = P'(1) <<< (S - 1);

   // stage A: partial products
   logic                   va_ff, ready_a;
   ctl_type                ctla_ff;
   logic signed [PHW-1:0]  phx_ff, phy_ff, phx_in, phy_in;
   logic signed [PLW-1:0]  plx_ff, ply_ff, plx_in, ply_in;
   logic signed [HEAD_OUT_W-1:0] hda_ff, hd_in;
   logic signed [ZW-1:0]   zr;

   // stage B: rounded Q12 values
   logic                   vb_ff, ready_b;
   ctl_type                ctlb_ff;
   logic signed [P-1:0]    sumx, sumy;
   logic signed [QW-1:0]   qx_ff, qy_ff, qx_in, qy_in;
   logic signed [HEAD_OUT_W-1:0] hdb_ff;

   // stage C: response register
   logic                   vc_ff, ready_c;
   logic signed [COORD_OUT_W-1:0] ox_ff, oy_ff, ox_in, oy_in;
   logic [MAG_OUT_W-1:0]   mag_ff, mag_in;
   logic signed [HEAD_OUT_W-1:0]  hdc_ff, hdc_in;

   assign ready_c  = !vc_ff || rsp_ready;
   assign ready_b  = !vb_ff || ready_c;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   assign phx_in = $signed(in_x[W-1:L]) * KGAIN;
   assign phy_in = $signed(in_y[W-1:L]) * KGAIN;
   assign plx_in = $signed({1'b0, in_x[L-1:0]}) * KGAIN;
   assign ply_in = $signed({1'b0, in_y[L-1:0]}) * KGAIN;
   assign zr     = in_z + HEADING_RND;
   assign hd_in  = zr[31:16];

   assign sumx  = (P'(phx_ff) <<< L) + P'(plx_ff) + RND;
   assign sumy  = (P'(phy_ff) <<< L) + P'(ply_ff) + RND;
   assign qx_in = QW'(sumx >>> S);
   assign qy_in = QW'(sumy >>> S);

   always_comb begin
      ox_in  = '0;
      oy_in  = '0;
      mag_in = '0;
      hdc_in = '0;
      unique case (ctlb_ff.op)
         OP_ROTATE, OP_POLAR: begin
            priority if (qx_ff < COORD_MIN) begin
               ox_in = COORD_OUT_W'(COORD_MIN);
            end else if (qx_ff > COORD_MAX) begin
               ox_in = COORD_OUT_W'(COORD_MAX);
            end else begin
               ox_in = qx_ff[COORD_OUT_W-1:0];
            end
            priority if (qy_ff < COORD_MIN) begin
               oy_in = COORD_OUT_W'(COORD_MIN);
            end else if (qy_ff > COORD_MAX) begin
               oy_in = COORD_OUT_W'(COORD_MAX);
            end else begin
               oy_in = qy_ff[COORD_OUT_W-1:0];
            end
         end
         OP_VECTOR: begin
            if (!ctlb_ff.zero_vec) begin
               priority if (qx_ff < 0) begin
                  mag_in = '0;
               end else if (qx_ff > MAG_MAX) begin
                  mag_in = MAG_OUT_W'(MAG_MAX);
               end else begin
                  mag_in = qx_ff[MAG_OUT_W-1:0];
               end
               hdc_in = hdb_ff;
            end
         end
         default: begin
            ox_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            va_ff <= in_valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
         if (ready_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_a) begin
         ctla_ff <= in_ctl;
         phx_ff  <= phx_in;
         phy_ff  <= phy_in;
         plx_ff  <= plx_in;
         ply_ff  <= ply_in;
         hda_ff  <= hd_in;
      end
      if (va_ff && ready_b) begin
         ctlb_ff <= ctla_ff;
         qx_ff   <= qx_in;
         qy_ff   <= qy_in;
         hdb_ff  <= hda_ff;
      end
      if (vb_ff && ready_c) begin
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         mag_ff <= mag_in;
         hdc_ff <= hdc_in;
      end
   end

   assign rsp_valid     = vc_ff;
   assign rsp_out_x     = ox_ff;
   assign rsp_out_y     = oy_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_heading   = hdc_ff;

endmodule

[rtl/vector_rotate_and_polar_unit.sv]
// Fixed-point CORDIC vector unit: rotate, length and heading, polar to
// cartesian, one request per clock. A request passes one entry stage, one
// micro-rotation stage per iteration (min(ITERATIONS, 24)) and three gain
// stages, each registered, before its response appears; each stage holds
// its item and moves on as soon as the next stage frees, so a new request
// is taken every cycle while rsp_ready stays high or while any stage is
// empty. Coordinates are Q3.12 in, Q4.12 out; angles are 16-bit binary
// angles (32768 is pi). Depends on vrp_pkg, vrp_prerot, vrp_cell and
// vrp_gain.
module vector_rotate_and_polar_unit #(
   parameter int ITERATIONS = 16,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_op,
   input  logic signed [15:0]                      req_x_in,
   input  logic signed [15:0]                      req_y_in,
   input  logic signed [15:0]                      req_angle,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [vrp_pkg::COORD_OUT_W-1:0]  rsp_out_x,
   output logic signed [vrp_pkg::COORD_OUT_W-1:0]  rsp_out_y,
   output logic [vrp_pkg::MAG_OUT_W-1:0]           rsp_magnitude,
   output logic signed [vrp_pkg::HEAD_OUT_W-1:0]   rsp_heading
);
   import vrp_pkg::*;

   localparam int W = DATA_WIDTH + GUARD_BITS;
   localparam int N = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;

   logic                 valid_c [N+1];
   logic                 ready_c [N+1];
   ctl_type              ctl_c   [N+1];
   logic signed [W-1:0]  x_c     [N+1];
   logic signed [W-1:0]  y_c     [N+1];
   logic signed [ZW-1:0] z_c     [N+1];

   vrp_prerot #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_prerot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_op     (req_op),
      .in_x      (req_x_in),
      .in_y      (req_y_in),
      .in_angle  (req_angle),
      .out_valid (valid_c[0]),
      .out_ready (ready_c[0]),
      .out_ctl   (ctl_c[0]),
      .out_x     (x_c[0]),
      .out_y     (y_c[0]),
      .out_z     (z_c[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_stage
      vrp_cell #(
         .W     (W),
         .INDEX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_c[i]),
         .in_ready  (ready_c[i]),
         .in_ctl    (ctl_c[i]),
         .in_x      (x_c[i]),
         .in_y      (y_c[i]),
         .in_z      (z_c[i]),
         .out_valid (valid_c[i+1]),
         .out_ready (ready_c[i+1]),
         .out_ctl   (ctl_c[i+1]),
         .out_x     (x_c[i+1]),
         .out_y     (y_c[i+1]),
         .out_z     (z_c[i+1])
      );
   end

   vrp_gain #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_gain (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (valid_c[N]),
      .in_ready      (ready_c[N]),
      .in_ctl        (ctl_c[N]),
      .in_x          (x_c[N]),
      .in_y          (y_c[N]),
      .in_z          (z_c[N]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_magnitude (rsp_magnitude),
      .rsp_heading   (rsp_heading)
   );

endmodule

[rtl/vrp_checker.sv]
// Port-level checks for vector_rotate_and_polar_unit, bound to the top level.
// Depends on vrp_pkg for field widths.
module vrp_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic [1:0]                              req_op,
   input logic signed [15:0]                      req_x_in,
   input logic signed [15:0]                      req_y_in,
   input logic signed [15:0]                      req_angle,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [vrp_pkg::COORD_OUT_W-1:0]  rsp_out_x,
   input logic signed [vrp_pkg::COORD_OUT_W-1:0]  rsp_out_y,
   input logic [vrp_pkg::MAG_OUT_W-1:0]           rsp_magnitude,
   input logic signed [vrp_pkg::HEAD_OUT_W-1:0]   rsp_heading
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_magnitude) && $stable(rsp_heading))
      else $error("stalled response changed");

   // drop all responses on reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // only a full, stalled pipeline may refuse a request
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without back-pressure");

   // polar fields and cartesian fields never both carry data
   a_fields_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_magnitude != '0 || rsp_heading != '0)
         |-> rsp_out_x == '0 && rsp_out_y == '0)
      else $error("cartesian and polar fields both set");

endmodule

bind vector_rotate_and_polar_unit vrp_checker u_checker (.*);

[sim/tb_vector_rotate_and_polar_unit.sv]
`timescale 1ns / 100ps
// Self-checking bench for vector_rotate_and_polar_unit: rotate, length/heading and
// polar-to-cartesian requests against a bit-exact CORDIC predictor held locally.
// Depends on rtl/vrp_pkg.sv and rtl/vector_rotate_and_polar_unit.sv.
module tb_vector_rotate_and_polar_unit;
   import vrp_pkg::*;

   localparam int ITERS      = 16;
   localparam int DW         = 16;
   localparam int N_ITER     = (ITERS > 24) ? 24 : ITERS;
   localparam int LATENCY    = N_ITER + 4;
   localparam int GAIN_SHIFT = DW + 12;
   localparam longint QUARTER = 64'sd1073741824;
   localparam longint GAIN    = 64'sd10187702;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam longint ARC_TAB [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   typedef struct packed {
      logic [1:0]         op;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] angle;
   } request_t;

   typedef struct packed {
      logic signed [16:0] out_x;
      logic signed [16:0] out_y;
      logic [15:0]        magnitude;
      logic signed [15:0] heading;
   } vector_result_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op = '0;
   logic signed [15:0] req_x_in = '0;
   logic signed [15:0] req_y_in = '0;
   logic signed [15:0] req_angle = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [16:0] rsp_out_x;
   logic signed [16:0] rsp_out_y;
   logic [15:0]        rsp_magnitude;
   logic signed [15:0] rsp_heading;

   request_t       req_backlog[$];
   vector_result_t predicted_results[$];
   request_t       next_req;
   vector_result_t want;
   logic           req_fire = 1'b0;
   bit             quiet = 1'b0;
   bit             long_hold_done = 1'b0;
   int             gap_left = 0;
   int             stall_left = 0;
   int             accepted_cnt = 0;
   int             err_count = 0;

   vector_rotate_and_polar_unit #(
      .ITERATIONS(ITERS),
      .DATA_WIDTH(DW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_x_in(req_x_in),
      .req_y_in(req_y_in),
      .req_angle(req_angle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_magnitude(rsp_magnitude),
      .rsp_heading(rsp_heading)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint scale_in(logic signed [15:0] q);
      if (DW >= 12)
         return longint'(q) <<< (DW - 12);
      return longint'(q) >>> (12 - DW);
   endfunction

   function automatic longint gain_round(longint v);
      return (v * GAIN + (64'sd1 <<< (GAIN_SHIFT - 1))) >>> GAIN_SHIFT;
   endfunction

   function automatic longint saturate(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic vector_result_t predict_cordic(request_t rq);
      vector_result_t r;
      longint x, y, z, t, dx, dy;
      r = '0;
      if (rq.op == OP_ROTATE || rq.op == OP_POLAR) begin
         x = scale_in(rq.x);
         y = (rq.op == OP_ROTATE) ? scale_in(rq.y) : 64'sd0;
         z = longint'(rq.angle) * 65536;
         if (z > QUARTER) begin
            t = x; x = -y; y = t; z = z - QUARTER;
         end else if (z < -QUARTER) begin
            t = x; x = y; y = -t; z = z + QUARTER;
         end
         for (int i = 0; i < N_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - ARC_TAB[i];
            end else begin
               x = x + dx; y = y - dy; z = z + ARC_TAB[i];
            end
         end
         r.out_x = 17'(saturate(gain_round(x), COORD_MIN, COORD_MAX));
         r.out_y = 17'(saturate(gain_round(y), COORD_MIN, COORD_MAX));
      end else if (rq.op == OP_VECTOR && (rq.x != 0 || rq.y != 0)) begin
         x = scale_in(rq.x);
         y = scale_in(rq.y);
         z = 0;
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; z = QUARTER;
            end else begin
               t = x; x = -y; y = t; z = -QUARTER;
            end
         end
         for (int i = 0; i < N_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx; y = y - dy; z = z + ARC_TAB[i];
            end else begin
               x = x - dx; y = y + dy; z = z - ARC_TAB[i];
            end
         end
         r.magnitude = 16'(saturate(gain_round(x), 0, MAG_MAX));
         r.heading   = 16'((z + 32768) >>> 16);
      end
      return r;
   endfunction

   function automatic bit idle_allowed();
      return !quiet && ((accepted_cnt / 32) % 4 != 3);
   endfunction

   task automatic compare_field(input string name, input logic signed [17:0] exp_v,
                                input logic signed [17:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
         err_count++;
      end
   endtask

   // drive requests; hold the payload until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || req_fire) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (idle_allowed() && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            gap_left  <= $urandom_range(0, 16);
         end else if (req_backlog.size() != 0) begin
            next_req  = req_backlog.pop_front();
            req_valid <= 1'b1;
            req_op    <= next_req.op;
            req_x_in  <= next_req.x;
            req_y_in  <= next_req.y;
            req_angle <= next_req.angle;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure, with one long hold to fill the pipeline
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!long_hold_done && accepted_cnt >= 60) begin
         long_hold_done = 1'b1;
         rsp_ready  <= 1'b0;
         stall_left <= 150;
      end else if (idle_allowed() && $urandom_range(0, 11) == 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predicted_results.push_back(predict_cordic('{req_op, req_x_in, req_y_in,
                                                         req_angle}));
            accepted_cnt++;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               $error("response with no request outstanding");
               err_count++;
            end else begin
               want = predicted_results.pop_front();
               compare_field("out_x", want.out_x, rsp_out_x);
               compare_field("out_y", want.out_y, rsp_out_y);
               compare_field("magnitude", want.magnitude, rsp_magnitude);
               compare_field("heading", want.heading, rsp_heading);
            end
         end
      end
   end

   task automatic add_request(input logic [1:0] op, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] a);
      req_backlog.push_back('{op, x, y, a});
   endtask

   function automatic logic signed [15:0] random_coord();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1: return 16'($urandom_range(0, 31)) - 16'sd16;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] random_angle();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         2: return $urandom_range(0, 1) ? 16'sd16385 : -16'sd16385;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_random(input int count);
      logic [1:0] op;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 19);
         op = (r < 6) ? OP_ROTATE : (r < 12) ? OP_VECTOR : (r < 18) ? OP_POLAR : OP_UNUSED;
         add_request(op, random_coord(), random_coord(), random_angle());
      end
   endtask

   // once the backlog is empty and nothing is offered, wait out the pipeline
   task automatic wait_for_drain();
      while (req_backlog.size() != 0 || req_valid)
         @(posedge clock);
      while (predicted_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      add_request(OP_ROTATE, 16'sd4096, 16'sd0, 16'sd0);
      add_request(OP_ROTATE, 16'sh7fff, 16'sh7fff, 16'sd8192);
      add_request(OP_ROTATE, 16'sh8000, 16'sh8000, 16'sh8000);
      add_request(OP_ROTATE, 16'sh7fff, 16'sh8000, 16'sh7fff);
      add_request(OP_ROTATE, 16'sd4096, 16'sd4096, 16'sd16384);
      add_request(OP_ROTATE, 16'sd4096, -16'sd4096, 16'sd16385);
      add_request(OP_ROTATE, 16'sd4096, 16'sd4096, -16'sd16384);
      add_request(OP_ROTATE, -16'sd4096, 16'sd2048, -16'sd16385);
      add_request(OP_VECTOR, 16'sd0, 16'sd0, 16'sd1234);
      add_request(OP_VECTOR, -16'sd4096, 16'sd0, 16'sd0);
      add_request(OP_VECTOR, -16'sd1, 16'sd0, 16'sh7fff);
      add_request(OP_VECTOR, 16'sh7fff, 16'sh7fff, 16'sd0);
      add_request(OP_VECTOR, 16'sh8000, 16'sh8000, 16'sd0);
      add_request(OP_VECTOR, 16'sh8000, 16'sd0, 16'sd0);
      add_request(OP_VECTOR, 16'sd0, 16'sh7fff, 16'sd0);
      add_request(OP_VECTOR, 16'sd0, 16'sh8000, 16'sd0);
      add_request(OP_VECTOR, 16'sd1, -16'sd1, 16'sd0);
      add_request(OP_POLAR, 16'sd4096, 16'sd7777, 16'sd0);
      add_request(OP_POLAR, -16'sd4096, 16'sd0, 16'sd8192);
      add_request(OP_POLAR, 16'sh7fff, 16'sd0, 16'sh8000);
      add_request(OP_POLAR, 16'sh8000, 16'sh7fff, 16'sh7fff);
      add_request(OP_POLAR, 16'sd0, 16'sd0, 16'sd12345);
      add_request(OP_UNUSED, 16'shffff, 16'shffff, 16'shffff);
      add_request(OP_UNUSED, 16'sd0, 16'sd0, 16'sd0);
      wait_for_drain();

      add_random(360);
      wait_for_drain();

      quiet = 1'b1;
      add_random(60);
      wait_for_drain();

      repeat (2 * LATENCY) @(posedge clock);
      if (err_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
